// File: rtl/abkf_pkg.sv
// Shared types, register codes and fixed-point helpers for the angle/bias
// Kalman filter. No dependencies; imported by all but the checker.
`timescale 1ns / 1ps

package abkf_pkg;

    // Operand width of the shared multiplier and the width of its product.
    localparam int MUL_W  = 40;
    localparam int PROD_W = 2 * MUL_W;
    // Width of intermediate sums: a product plus a state value, with headroom.
    localparam int WIDE_W = PROD_W + 2;
    // Width of the innovation variance (P00 plus a rescaled noise value).
    localparam int DEN_W  = 34;
    // Fraction bits of the time step.
    localparam int DT_FRAC = 24;

    typedef logic signed [MUL_W-1:0]  mul_op_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_Q_ANGLE = 2'd0;
    localparam logic [1:0] REG_Q_BIAS  = 2'd1;
    localparam logic [1:0] REG_R_MEAS  = 2'd2;

    localparam wide_t WIDE_MAX = 82'sd2147483647;
    localparam wide_t WIDE_MIN = -82'sd2147483648;

    // Clamp a wide value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input wide_t v);
        logic signed [31:0] r;
        if (v > WIDE_MAX)
            r = 32'sh7fffffff;
        else if (v < WIDE_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Shift right with rounding to nearest, ties toward plus infinity.
    function automatic wide_t round_shr(input wide_t v, input int sh);
        wide_t one;
        one = 1;
        return (v + (one <<< (sh - 1))) >>> sh;
    endfunction

endpackage

// File: rtl/abkf_mul.sv
// Shared sequential multiplier: signed 40 x 40 bits, one 8-bit digit a cycle.
// Depends on abkf_pkg for operand and product types.
`timescale 1ns / 1ps

module abkf_mul
    import abkf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  mul_op_t op_a,
    input  mul_op_t op_b,
    output logic    done,
    output prod_t   prod
);

    localparam int DIGITS = MUL_W / 8;

    logic [PROD_W-1:0] a_sh_reg, a_sh_next;
    logic [MUL_W-1:0]  b_reg, b_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    prod_t             prod_reg, prod_next;
    logic [MUL_W-1:0]  mag_a, mag_b;

    always_comb
    begin
        mag_a     = op_a[MUL_W-1] ? MUL_W'(-op_a) : MUL_W'(op_a);
        mag_b     = op_b[MUL_W-1] ? MUL_W'(-op_b) : MUL_W'(op_b);
        a_sh_next = a_sh_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        prod_next = prod_reg;
        if (start)
        begin
            a_sh_next = PROD_W'(mag_a);
            b_next    = mag_b;
            acc_next  = '0;
            neg_next  = op_a[MUL_W-1] ^ op_b[MUL_W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 3'(DIGITS))
            begin
                // Final cycle applies the sign.
                prod_next = neg_reg ? prod_t'(-acc_reg) : prod_t'(acc_reg);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                acc_next  = acc_reg + a_sh_reg * PROD_W'(b_reg[7:0]);
                a_sh_next = a_sh_reg << 8;
                b_next    = b_reg >> 8;
                cnt_next  = cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sh_reg <= a_sh_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// File: rtl/abkf_div.sv
// Restoring divider for the Kalman gain: (P << C) / S, truncated, saturated.
// One quotient bit a cycle. Depends on abkf_pkg for the divisor width.
`timescale 1ns / 1ps

module abkf_div
    import abkf_pkg::*;
#(
    parameter int COV_FRAC_BITS = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [31:0]      num,
    input  logic signed [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [31:0]      quot
);

    localparam int DVD_W = 32 + COV_FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic signed [31:0] quot_reg, quot_next;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_sub;
    logic [31:0]      mag_num;
    logic             big_pos, big_neg;

    always_comb
    begin
        mag_num = num[31] ? 32'(-num) : 32'(num);
        rem_sh  = {rem_reg, num_reg[DVD_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
        big_pos = num_reg > {{(DVD_W-32){1'b0}}, 32'h7fffffff};
        big_neg = num_reg > {{(DVD_W-32){1'b0}}, 32'h80000000};
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        if (start)
        begin
            num_next  = {mag_num, {COV_FRAC_BITS{1'b0}}};
            den_next  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            rem_next  = '0;
            neg_next  = num[31] ^ den[DEN_W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(DVD_W))
            begin
                if (neg_reg)
                    quot_next = big_neg ? 32'sh80000000 : 32'(-num_reg[31:0]);
                else
                    quot_next = big_pos ? 32'sh7fffffff : num_reg[31:0];
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                rem_next = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                num_next = {num_reg[DVD_W-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: rtl/angle_bias_kalman_filter_core.sv
// Top level of the two-state angle/bias Kalman filter: sequencer and state.
// Depends on abkf_pkg, abkf_mul and abkf_div.
`timescale 1ns / 1ps

// Each input transaction carries a measured angle and a gyro rate (signed,
// 16 fraction bits) and a time step (unsigned Q1.24). The block predicts the
// angle, propagates the 2x2 error covariance, forms both gains by division by
// the innovation variance, corrects angle and bias, and returns the new angle
// as one output transaction. Ten products pass one after the other through a
// single shared multiplier, and each holds the sequencer until it is done.
// The two gains go through one restoring divider at one quotient bit a cycle.
// The remaining steps are accept, rate, inner-term, gain-setup and output.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register, so the next item may be taken before it is read.
// A result that is still waiting when the next one is ready stalls the
// output step until it is read.
// When the innovation variance is exactly zero both gains are zero and the
// divider is skipped. The noise registers sit at byte addresses 0, 4 and 8
// on the APB port; writes to address 12 are ignored, it reads back as zero,
// and paddr[1:0] is not decoded.

module angle_bias_kalman_filter_core
    import abkf_pkg::*;
#(
    parameter int COV_FRAC_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream: measured_angle [31:0], measured_rate [63:32],
    // step_time [88:64], zero fill above.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,
    // Output stream: filtered_angle [31:0].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NSH_L = (COV_FRAC_BITS >= 24) ? COV_FRAC_BITS - 24 : 0;
    localparam int NSH_R = (COV_FRAC_BITS < 24) ? 24 - COV_FRAC_BITS : 0;
    localparam logic signed [31:0] ONE_COV = 32'sd1 <<< COV_FRAC_BITS;

    typedef enum logic [16:0] {
        ST_IDLE   = 17'h00001,
        ST_RATE   = 17'h00002,
        ST_M_ANG  = 17'h00004,
        ST_M_T    = 17'h00008,
        ST_INNER  = 17'h00010,
        ST_M_P00  = 17'h00020,
        ST_M_P11  = 17'h00040,
        ST_GAIN   = 17'h00080,
        ST_D_K0   = 17'h00100,
        ST_D_K1   = 17'h00200,
        ST_M_ANG2 = 17'h00400,
        ST_M_BIAS = 17'h00800,
        ST_M_P10  = 17'h01000,
        ST_M_P11B = 17'h02000,
        ST_M_P00B = 17'h04000,
        ST_M_P01  = 17'h08000,
        ST_OUT    = 17'h10000
    } state_t;

    // Rescale a Q0.24 noise value to the covariance format.
    function automatic wide_t noise_to_cov(input logic [23:0] x);
        wide_t v;
        wide_t rnd;
        v   = wide_t'({1'b0, x});
        rnd = (NSH_R > 0) ? (wide_t'(1) <<< (NSH_R - 1)) : wide_t'(0);
        if (COV_FRAC_BITS >= 24)
            return v <<< NSH_L;
        return (v + rnd) >>> NSH_R;
    endfunction

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;

    logic [23:0] qa_reg, qa_next;
    logic [23:0] qb_reg, qb_next;
    logic [23:0] rm_reg, rm_next;

    logic signed [31:0] ang_reg, ang_next;
    logic signed [31:0] bias_reg, bias_next;
    logic signed [31:0] p00_reg, p00_next;
    logic signed [31:0] p01_reg, p01_next;
    logic signed [31:0] p10_reg, p10_next;
    logic signed [31:0] p11_reg, p11_next;

    logic signed [31:0]      meas_reg, meas_next;
    logic signed [31:0]      rin_reg, rin_next;
    logic [24:0]             dt_reg, dt_next;
    logic signed [31:0]      rate_reg, rate_next;
    logic signed [35:0]      t_reg, t_next;
    logic signed [35:0]      inner_reg, inner_next;
    logic signed [DEN_W-1:0] s_reg, s_next;
    logic signed [31:0]      y_reg, y_next;
    logic signed [31:0]      k0_reg, k0_next;
    logic signed [31:0]      k1_reg, k1_next;

    logic        mv_reg, mv_next;
    logic [31:0] md_reg, md_next;

    logic    mul_start, mul_done;
    mul_op_t mul_a, mul_b;
    prod_t   mul_prod;
    logic    div_start, div_done;
    logic signed [31:0] div_num, div_quot;

    wide_t   prod_w, rs_dt, rs_cov, qa_c, qb_c, rm_c, s_full, inner_full;
    logic    cfg_wr, in_acc;
    mul_op_t dt_op;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_Q_ANGLE: prdata = {8'd0, qa_reg};
            REG_Q_BIAS:  prdata = {8'd0, qb_reg};
            REG_R_MEAS:  prdata = {8'd0, rm_reg};
            default:     prdata = 32'd0;
        endcase
    end

    abkf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    abkf_div #(
        .COV_FRAC_BITS (COV_FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Operand selection for the shared multiplier and divider.
    always_comb
    begin
        dt_op     = mul_op_t'({1'b0, dt_reg});
        qb_c      = noise_to_cov(qb_reg);
        mul_a     = dt_op;
        mul_b     = mul_op_t'(rate_reg);
        mul_start = 1'b0;
        div_start = 1'b0;
        div_num   = p00_reg;
        unique case (state_reg)
            ST_M_ANG:  mul_b = mul_op_t'(rate_reg);
            ST_M_T:    mul_b = mul_op_t'(p11_reg);
            ST_M_P00:  mul_b = mul_op_t'(inner_reg);
            ST_M_P11:
            begin
                mul_a = mul_op_t'(qb_c);
                mul_b = dt_op;
            end
            ST_M_ANG2:
            begin
                mul_a = mul_op_t'(k0_reg);
                mul_b = mul_op_t'(y_reg);
            end
            ST_M_BIAS:
            begin
                mul_a = mul_op_t'(k1_reg);
                mul_b = mul_op_t'(y_reg);
            end
            ST_M_P10:
            begin
                mul_a = mul_op_t'(k1_reg);
                mul_b = mul_op_t'(p00_reg);
            end
            ST_M_P11B:
            begin
                mul_a = mul_op_t'(k1_reg);
                mul_b = mul_op_t'(p01_reg);
            end
            ST_M_P00B:
            begin
                mul_a = mul_op_t'(k0_reg);
                mul_b = mul_op_t'(p00_reg);
            end
            ST_M_P01:
            begin
                mul_a = mul_op_t'(k0_reg);
                mul_b = mul_op_t'(p01_reg);
            end
            ST_D_K1:   div_num = p10_reg;
            default:
            begin
                mul_a = dt_op;
            end
        endcase
        if (!issued_reg)
        begin
            mul_start = (state_reg == ST_M_ANG)  || (state_reg == ST_M_T)
                     || (state_reg == ST_M_P00)  || (state_reg == ST_M_P11)
                     || (state_reg == ST_M_ANG2) || (state_reg == ST_M_BIAS)
                     || (state_reg == ST_M_P10)  || (state_reg == ST_M_P11B)
                     || (state_reg == ST_M_P00B) || (state_reg == ST_M_P01);
            div_start = (state_reg == ST_D_K0) || (state_reg == ST_D_K1);
        end
    end

    // Sequencer and state updates.
    always_comb
    begin
        prod_w     = wide_t'(mul_prod);
        rs_dt      = round_shr(prod_w, DT_FRAC);
        rs_cov     = round_shr(prod_w, COV_FRAC_BITS);
        qa_c       = noise_to_cov(qa_reg);
        rm_c       = noise_to_cov(rm_reg);
        s_full     = wide_t'(p00_reg) + rm_c;
        inner_full = wide_t'(t_reg) - wide_t'(p01_reg) - wide_t'(p10_reg) + qa_c;

        state_next  = state_reg;
        issued_next = issued_reg;
        qa_next     = qa_reg;
        qb_next     = qb_reg;
        rm_next     = rm_reg;
        ang_next    = ang_reg;
        bias_next   = bias_reg;
        p00_next    = p00_reg;
        p01_next    = p01_reg;
        p10_next    = p10_reg;
        p11_next    = p11_reg;
        meas_next   = meas_reg;
        rin_next    = rin_reg;
        dt_next     = dt_reg;
        rate_next   = rate_reg;
        t_next      = t_reg;
        inner_next  = inner_reg;
        s_next      = s_reg;
        y_next      = y_reg;
        k0_next     = k0_reg;
        k1_next     = k1_reg;
        md_next     = md_reg;
        mv_next     = mv_reg & ~m_tready;

        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_Q_ANGLE: qa_next = pwdata[23:0];
                REG_Q_BIAS:  qb_next = pwdata[23:0];
                REG_R_MEAS:  rm_next = pwdata[23:0];
                default:     qa_next = qa_reg;
            endcase
        end

        if (mul_start || div_start)
            issued_next = 1'b1;
        if (mul_done || div_done)
            issued_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    meas_next  = s_tdata[31:0];
                    rin_next   = s_tdata[63:32];
                    dt_next    = s_tdata[88:64];
                    state_next = ST_RATE;
                end
            end
            ST_RATE:
            begin
                rate_next  = sat32(wide_t'(rin_reg) - wide_t'(bias_reg));
                state_next = ST_M_ANG;
            end
            ST_M_ANG:
            begin
                if (mul_done)
                begin
                    ang_next   = sat32(wide_t'(ang_reg) + rs_dt);
                    state_next = ST_M_T;
                end
            end
            ST_M_T:
            begin
                if (mul_done)
                begin
                    t_next     = 36'(rs_dt);
                    state_next = ST_INNER;
                end
            end
            ST_INNER:
            begin
                // Uses the old P01 and P10, then moves both by t.
                inner_next = 36'(inner_full);
                p01_next   = sat32(wide_t'(p01_reg) - wide_t'(t_reg));
                p10_next   = sat32(wide_t'(p10_reg) - wide_t'(t_reg));
                state_next = ST_M_P00;
            end
            ST_M_P00:
            begin
                if (mul_done)
                begin
                    p00_next   = sat32(wide_t'(p00_reg) + rs_dt);
                    state_next = ST_M_P11;
                end
            end
            ST_M_P11:
            begin
                if (mul_done)
                begin
                    p11_next   = sat32(wide_t'(p11_reg) + rs_dt);
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                s_next  = DEN_W'(s_full);
                y_next  = sat32(wide_t'(meas_reg) - wide_t'(ang_reg));
                k0_next = '0;
                k1_next = '0;
                // A zero innovation variance leaves both gains at zero.
                state_next = (s_full == '0) ? ST_M_ANG2 : ST_D_K0;
            end
            ST_D_K0:
            begin
                if (div_done)
                begin
                    k0_next    = div_quot;
                    state_next = ST_D_K1;
                end
            end
            ST_D_K1:
            begin
                if (div_done)
                begin
                    k1_next    = div_quot;
                    state_next = ST_M_ANG2;
                end
            end
            ST_M_ANG2:
            begin
                if (mul_done)
                begin
                    ang_next   = sat32(wide_t'(ang_reg) + rs_cov);
                    state_next = ST_M_BIAS;
                end
            end
            ST_M_BIAS:
            begin
                if (mul_done)
                begin
                    bias_next  = sat32(wide_t'(bias_reg) + rs_cov);
                    state_next = ST_M_P10;
                end
            end
            ST_M_P10:
            begin
                if (mul_done)
                begin
                    p10_next   = sat32(wide_t'(p10_reg) - rs_cov);
                    state_next = ST_M_P11B;
                end
            end
            ST_M_P11B:
            begin
                if (mul_done)
                begin
                    p11_next   = sat32(wide_t'(p11_reg) - rs_cov);
                    state_next = ST_M_P00B;
                end
            end
            ST_M_P00B:
            begin
                if (mul_done)
                begin
                    p00_next   = sat32(wide_t'(p00_reg) - rs_cov);
                    state_next = ST_M_P01;
                end
            end
            ST_M_P01:
            begin
                if (mul_done)
                begin
                    p01_next   = sat32(wide_t'(p01_reg) - rs_cov);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!mv_reg || m_tready)
                begin
                    md_next    = ang_reg;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            mv_reg     <= 1'b0;
            qa_reg     <= 24'd16777;
            qb_reg     <= 24'd50332;
            rm_reg     <= 24'd503316;
            ang_reg    <= '0;
            bias_reg   <= '0;
            p00_reg    <= ONE_COV;
            p01_reg    <= '0;
            p10_reg    <= '0;
            p11_reg    <= ONE_COV;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            mv_reg     <= mv_next;
            qa_reg     <= qa_next;
            qb_reg     <= qb_next;
            rm_reg     <= rm_next;
            ang_reg    <= ang_next;
            bias_reg   <= bias_next;
            p00_reg    <= p00_next;
            p01_reg    <= p01_next;
            p10_reg    <= p10_next;
            p11_reg    <= p11_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg  <= meas_next;
        rin_reg   <= rin_next;
        dt_reg    <= dt_next;
        rate_reg  <= rate_next;
        t_reg     <= t_next;
        inner_reg <= inner_next;
        s_reg     <= s_next;
        y_reg     <= y_next;
        k0_reg    <= k0_next;
        k1_reg    <= k1_next;
        md_reg    <= md_next;
    end

endmodule

// File: rtl/abkf_checker.sv
// Port-level checker for the angle/bias Kalman filter core, bound to the top.
// Depends on angle_bias_kalman_filter_core for its port names.
`timescale 1ns / 1ps

module abkf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        pready
);

    // A waiting result is not withdrawn.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // The data of a waiting result stays put.
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // The block is busy right after it takes an input transaction.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // No result appears in the cycle after an input is taken.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

    // The configuration port never waits.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind angle_bias_kalman_filter_core abkf_checker u_abkf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

// File: dv/angle_bias_kalman_filter_core_tb.sv
// Self-checking testbench for the angle/bias Kalman filter core.
// Depends on abkf_pkg and the RTL of angle_bias_kalman_filter_core.
`timescale 1ns / 1ps

module angle_bias_kalman_filter_core_tb
    import abkf_pkg::*;
();

    localparam int CFB = 24;
    localparam int LATENCY = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    angle_bias_kalman_filter_core #(.COV_FRAC_BITS(CFB)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // The clock runs with a 12 ns period.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Filter state kept by the predictor, in the block's own formats.
    logic signed [31:0] est_angle;
    logic signed [31:0] est_bias;
    logic signed [31:0] cov [4];
    logic [23:0]        noise_q_angle;
    logic [23:0]        noise_q_bias;
    logic [23:0]        noise_r;

    logic [95:0]        pending_items [$];
    logic [31:0]        expected_angles [$];
    int                 error_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    bit                 hold_send;
    int                 quiet_cycles;

    // Arithmetic helpers. All of them work on 128-bit signed values so that
    // every product is exact.
    function automatic logic signed [127:0] shr_round(input logic signed [127:0] v,
                                                      input int sh);
        logic signed [127:0] one;
        one = 1;
        return (v + (one <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        logic signed [31:0] r;
        if (v > 128'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -128'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [127:0] noise_scaled(input logic [23:0] x);
        logic signed [127:0] v;
        v = {104'd0, x};
        if (CFB >= 24)
            return v <<< (CFB - 24);
        return shr_round(v, 24 - CFB);
    endfunction

    // Runs one filter step on the predictor state and returns the new angle.
    function automatic logic [31:0] kalman_step(input logic [95:0] item);
        logic signed [127:0] meas, rin, dt, p00, p01, p10, p11;
        logic signed [127:0] rate, t, inner, s, k0, k1, y, num;
        meas = {{96{item[31]}}, item[31:0]};
        rin  = {{96{item[63]}}, item[63:32]};
        dt   = {103'd0, item[88:64]};
        p00 = cov[0];
        p01 = cov[1];
        p10 = cov[2];
        p11 = cov[3];
        rate = clamp32(rin - est_bias);
        est_angle = clamp32(est_angle + shr_round(dt * rate, DT_FRAC));
        t = shr_round(dt * p11, DT_FRAC);
        inner = t - p01 - p10 + noise_scaled(noise_q_angle);
        p00 = clamp32(p00 + shr_round(dt * inner, DT_FRAC));
        p01 = clamp32(p01 - t);
        p10 = clamp32(p10 - t);
        p11 = clamp32(p11 + shr_round(noise_scaled(noise_q_bias) * dt, DT_FRAC));
        s = p00 + noise_scaled(noise_r);
        k0 = 0;
        k1 = 0;
        // A zero innovation variance leaves both gains at zero.
        if (s != 0)
        begin
            num = p00 <<< CFB;
            k0 = clamp32(num / s);
            num = p10 <<< CFB;
            k1 = clamp32(num / s);
        end
        y = clamp32(meas - est_angle);
        est_angle = clamp32(est_angle + shr_round(k0 * y, CFB));
        est_bias  = clamp32(est_bias + shr_round(k1 * y, CFB));
        cov[0] = clamp32(p00 - shr_round(k0 * p00, CFB));
        cov[1] = clamp32(p01 - shr_round(k0 * p01, CFB));
        cov[2] = clamp32(p10 - shr_round(k1 * p00, CFB));
        cov[3] = clamp32(p11 - shr_round(k1 * p01, CFB));
        return est_angle;
    endfunction

    // Driver: presents queued items and predicts each accepted transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_angles.push_back(kalman_step(s_tdata));
                void'(pending_items.pop_front());
            end
            // A transaction that is still waiting keeps its data.
            if (s_tvalid && !s_tready)
                s_tvalid <= 1'b1;
            else if (pending_items.size() != 0 && !hold_send &&
                     $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_items[0];
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: checks every output transaction and applies receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready)
            begin
                if (expected_angles.size() == 0)
                begin
                    $display("%0t: unexpected filtered_angle, expected none, actual %h",
                             $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    if (m_tdata !== expected_angles[0])
                    begin
                        $display("%0t: filtered_angle mismatch, expected %h, actual %h",
                                 $time, expected_angles[0], m_tdata);
                        error_count++;
                    end
                    void'(expected_angles.pop_front());
                end
            end
        end
    end

    // Watchdog: ends the run if no transaction moves for too long.
    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Waits until the queue of items is drained and all results are checked.
    task automatic drain_all();
        while (pending_items.size() != 0 || s_tvalid || expected_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // APB write of one noise register; the predictor copy follows it.
    task automatic write_noise(input logic [1:0] idx, input logic [23:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {8'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_Q_ANGLE: noise_q_angle = value;
            REG_Q_BIAS:  noise_q_bias  = value;
            REG_R_MEAS:  noise_r       = value;
            default: ;
        endcase
    endtask

    task automatic set_noise(input logic [23:0] qa, input logic [23:0] qb,
                             input logic [23:0] r);
        write_noise(REG_Q_ANGLE, qa);
        write_noise(REG_Q_BIAS, qb);
        write_noise(REG_R_MEAS, r);
        @(posedge clk);
    endtask

    function automatic logic [95:0] pack_item(input logic [31:0] ang,
                                              input logic [31:0] rate,
                                              input logic [24:0] dt);
        return {7'd0, dt, rate, ang};
    endfunction

    // Random item: mostly realistic small angles and time steps, sometimes
    // full-range noise to reach the saturation paths.
    function automatic logic [95:0] random_item();
        logic [31:0] ang, rate;
        logic [24:0] dt;
        if ($urandom_range(9) < 7)
        begin
            ang  = $signed($urandom_range(0, 180 << 16)) - (90 << 16);
            rate = $signed($urandom_range(0, 1000 << 16)) - (500 << 16);
            dt   = 25'($urandom_range(1, 1 << 19));
        end
        else
        begin
            ang  = $urandom;
            rate = $urandom;
            dt   = 25'($urandom_range(0, 32'h1ffffff));
        end
        return pack_item(ang, rate, dt);
    endfunction

    initial
    begin
        error_count   = 0;
        send_idle_pct = 16;
        recv_idle_pct = 58;
        hold_send     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        noise_q_angle = 24'd16777;
        noise_q_bias  = 24'd50332;
        noise_r       = 24'd503316;
        est_angle     = '0;
        est_bias      = '0;
        cov[0] = 32'sd1 <<< CFB;
        cov[1] = '0;
        cov[2] = '0;
        cov[3] = 32'sd1 <<< CFB;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at reset settings: field extremes and big steps.
        pending_items.push_back(pack_item(32'h0001_0000, 32'h0, 25'h10000));
        pending_items.push_back(pack_item(32'h7fffffff, 32'h7fffffff, 25'h1000000));
        pending_items.push_back(pack_item(32'h80000000, 32'h80000000, 25'h1ffffff));
        pending_items.push_back(pack_item(32'h0, 32'hffffffff, 25'h0));
        pending_items.push_back(pack_item(32'hffffffff, 32'h1, 25'h1));
        pending_items.push_back(pack_item(32'h7fffffff, 32'h80000000, 25'h1000001));
        drain_all();

        // Extreme noise settings, including a maximum and a minimum.
        set_noise(24'hffffff, 24'hffffff, 24'hffffff);
        pending_items.push_back(pack_item(32'h0010_0000, 32'h0002_0000, 25'h1000000));
        pending_items.push_back(pack_item(32'hfff0_0000, 32'hfffe_0000, 25'h1ffffff));
        drain_all();
        set_noise(24'd0, 24'd0, 24'd1);
        for (int i = 0; i < 6; i++)
            pending_items.push_back(pack_item(32'h0, 32'h0, 25'h0));
        pending_items.push_back(pack_item(32'h0020_0000, 32'h0, 25'h80000));
        drain_all();

        // Sender pauses while random items are queued, then resumes.
        hold_send = 1'b1;
        for (int i = 0; i < 4; i++)
            pending_items.push_back(random_item());
        repeat (50) @(posedge clk);
        hold_send = 1'b0;
        drain_all();

        // Random phases with three idling profiles and fresh noise values.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 58 : 0;
            recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 16 : 0;
            set_noise(24'($urandom_range(0, 24'hffffff)),
                      24'($urandom_range(0, 24'hffffff)),
                      24'($urandom_range(1, 24'hffffff)));
            for (int i = 0; i < 360; i++)
                pending_items.push_back(random_item());
            drain_all();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
